FILE: design/pru_pkg.sv
`default_nettype none

package pru_pkg;

  // geometry limits
  localparam int MAX_ROW_PIXELS = 1024;
  localparam int MAX_SCALE      = 16;

  // field widths
  localparam int PIX_W     = 24;
  localparam int SCALE_W   = 5;
  localparam int WIDTH_W   = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // derived widths
  localparam int COL_W  = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int CNT_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SEFF_W = $clog2(MAX_SCALE + 1);
  localparam int WEFF_W = $clog2(MAX_ROW_PIXELS + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_COPY = 2'd0;
  localparam logic [1:0] KIND_PAD  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // operations
  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PIX_W-1:0] pixel_out;
    logic [1:0]       pad_bytes;
    logic             row_done;
    logic             last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_EMIT,
    ST_PAD,
    ST_ERR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       ready;
    logic       accept;
    logic       store_wr;
    logic       store_rd;
    logic       load_pix;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_last;
    logic       advance;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mismatch;
    logic in_op;
    logic copy_last;
    logic row_end;
    logic slot_free;
  } dp_stat_t;

endpackage : pru_pkg

`default_nettype wire

FILE: design/pixel_replication_upscaler_core.sv
// Nearest-neighbor integer upscaler for rows of 24-bit pixels.
// Input beats (in_valid/in_stall/in_data) carry either a new source pixel or a
// replay step. A pixel beat stores the pixel in the line buffer and produces
// scale copy beats; the beat that finishes a row adds one padding beat with
// the zero-byte count aligning the output row to 4 bytes. Until the row has
// gone out scale times, replay beats are expected, each re-emitting the next
// stored pixel. A beat of the wrong kind gives one error beat, state unchanged.
// Result beats leave on out_valid/out_stall/out_data; last marks the final
// beat of each input beat. The user must write config (cfg_we/cfg_index/
// cfg_wdata) while idle only; the block itself does not enforce this.
// An accepted pixel is registered and its copy beats then load the output
// register; a replay beat first waits for the line buffer read, which is
// registered. A copy counter in the datapath counts each input beat's copy
// beats up to scale, and the beat that ends a row adds its padding beat.
// Receiver stall holds the output register; the controller waits and in_stall
// stays high until the beat's results are all loaded. in_stall drops again
// while the last result may still be waiting to be taken.
// Reset: synchronous, active low; scale and row width return to 1, position
// and replay state clear. The line buffer is not cleared.
`default_nettype none

module pixel_replication_upscaler_core
  import pru_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire in_t                  in_data,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: accept, buffer read wait, copy loop, padding, error
  pru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // registers, line buffer, counters and output register
  pru_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign in_stall = !cmd.ready;

endmodule : pixel_replication_upscaler_core

`default_nettype wire

FILE: design/pru_ram.sv
`default_nettype none

module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : pru_ram

`default_nettype wire

FILE: design/pru_ctrl.sv
`default_nettype none

module pru_ctrl
  import pru_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire dp_stat_t   stat,
  output      ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.mismatch)              state_nxt = ST_ERR;
          else if (stat.in_op == OP_PIXEL) state_nxt = ST_EMIT;
          else                            state_nxt = ST_RDWAIT;
        end
      end
      ST_RDWAIT: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (stat.slot_free && stat.copy_last) begin
          state_nxt = stat.row_end ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (stat.slot_free) state_nxt = ST_IDLE;
      end
      ST_ERR: begin
        if (stat.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.ready    = 1'b1;
        cmd.accept   = in_valid;
        cmd.store_wr = in_valid && !stat.mismatch && (stat.in_op == OP_PIXEL);
        cmd.store_rd = in_valid && !stat.mismatch && (stat.in_op == OP_REPLAY);
      end
      ST_RDWAIT: cmd.load_pix = 1'b1;
      ST_EMIT: begin
        cmd.emit      = stat.slot_free;
        cmd.emit_kind = KIND_COPY;
        cmd.emit_last = stat.copy_last && !stat.row_end;
        cmd.advance   = stat.slot_free && stat.copy_last && !stat.row_end;
      end
      ST_PAD: begin
        cmd.emit      = stat.slot_free;
        cmd.emit_kind = KIND_PAD;
        cmd.emit_last = 1'b1;
        cmd.advance   = stat.slot_free;
      end
      ST_ERR: begin
        cmd.emit      = stat.slot_free;
        cmd.emit_kind = KIND_ERR;
        cmd.emit_last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule : pru_ctrl

`default_nettype wire

FILE: design/pru_dp.sv
`default_nettype none

module pru_dp
  import pru_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire in_t                  in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 out_stall,
  input  wire ctrl_cmd_t            cmd,
  output      dp_stat_t             stat,
  output      logic                 out_valid,
  output      out_t                 out_data
);

  logic [SCALE_W-1:0] scale_r;
  logic [WIDTH_W-1:0] width_r;
  logic [COL_W-1:0]   column_r;
  logic [CNT_W-1:0]   pass_r;
  logic               replaying_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PIX_W-1:0]   pix_r;
  logic               out_valid_r;
  out_t               out_r;

  logic [SEFF_W-1:0]  s_eff;
  logic [WEFF_W-1:0]  w_eff;
  logic [COL_W:0]     col_inc;
  logic [CNT_W:0]     pass_inc;
  logic [PIX_W-1:0]   ram_rdata;
  logic [1:0]         wxs;
  logic [1:0]         pad_calc;
  out_t               res;

  // out-of-range register values clamp to the legal range
  always_comb begin
    if (scale_r == '0)                  s_eff = SEFF_W'(1);
    else if (int'(scale_r) > MAX_SCALE) s_eff = SEFF_W'(MAX_SCALE);
    else                                s_eff = SEFF_W'(scale_r);

    if (width_r == '0)                       w_eff = WEFF_W'(1);
    else if (int'(width_r) > MAX_ROW_PIXELS) w_eff = WEFF_W'(MAX_ROW_PIXELS);
    else                                     w_eff = WEFF_W'(width_r);
  end

  assign col_inc  = {1'b0, column_r} + 1'b1;
  assign pass_inc = {1'b0, pass_r} + 1'b1;

  // 3 bytes per pixel: pad = -(w*s*3) mod 4, only low two bits matter
  assign wxs      = w_eff[1:0] * s_eff[1:0];
  assign pad_calc = 2'd0 - (wxs * 2'd3);

  assign stat.mismatch  = (in_data.operation != replaying_r);
  assign stat.in_op     = in_data.operation;
  assign stat.copy_last = (cnt_r == CNT_W'(s_eff - 1'b1));
  assign stat.row_end   = (WEFF_W'(col_inc) >= w_eff);
  assign stat.slot_free = !out_valid_r || !out_stall;

  pru_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_ROW_PIXELS)
  ) u_line (
    .clk   (clk),
    .we    (cmd.store_wr),
    .waddr (column_r),
    .wdata (in_data.pixel),
    .re    (cmd.store_rd),
    .raddr (column_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    res           = '0;
    res.kind      = cmd.emit_kind;
    res.last      = cmd.emit_last;
    case (cmd.emit_kind)
      KIND_COPY: res.pixel_out = pix_r;
      KIND_PAD: begin
        res.pad_bytes = pad_calc;
        res.row_done  = 1'b1;
      end
      default: res.pixel_out = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_W'(1);
      width_r     <= WIDTH_W'(1);
      column_r    <= '0;
      pass_r      <= '0;
      replaying_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE:     scale_r <= cfg_wdata[SCALE_W-1:0];
          REG_ROW_WIDTH: width_r <= cfg_wdata[WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (cmd.advance) begin
        if (stat.row_end) begin
          column_r <= '0;
          if (SEFF_W'(pass_inc) >= s_eff) begin
            pass_r      <= '0;
            replaying_r <= 1'b0;
          end else begin
            pass_r      <= pass_inc[CNT_W-1:0];
            replaying_r <= 1'b1;
          end
        end else begin
          column_r <= col_inc[COL_W-1:0];
        end
      end
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_r <= '0;
    end else if (cmd.emit && cmd.emit_kind == KIND_COPY) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.accept)        pix_r <= in_data.pixel;
    else if (cmd.load_pix) pix_r <= ram_rdata;
    if (cmd.emit)          out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule : pru_dp

`default_nettype wire

FILE: design/pru_chk.sv
`default_nettype none

module pru_chk
  import pru_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one input beat at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted beat while busy");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_PAD |->
      out_data.row_done && out_data.last && out_data.pixel_out == '0)
    else $error("bad padding beat");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ERR |->
      out_data.last && !out_data.row_done && out_data.pad_bytes == '0 &&
      out_data.pixel_out == '0)
    else $error("bad error beat");

  a_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_COPY |->
      !out_data.row_done && out_data.pad_bytes == '0)
    else $error("copy beat with padding fields");

endmodule : pru_chk

bind pixel_replication_upscaler_core pru_chk u_pru_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: sim/pixel_replication_upscaler_core_check.sv
`timescale 1ns / 100ps

module pixel_replication_upscaler_core_check
  import pru_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);

  // mirror of the block: line store, position, registers
  logic [PIX_W-1:0]   line_buf [MAX_ROW_PIXELS];
  logic [SCALE_W-1:0] scale_r;
  logic [WIDTH_W-1:0] width_r;
  int unsigned        column;
  int unsigned        row_pass;
  logic               replaying;

  out_t beats_due [$];
  out_t head;

  assign pending = beats_due.size();

  // expected result beats for one accepted input beat
  task automatic upscale_beat(input in_t b);
    int unsigned      s;
    int unsigned      w;
    int unsigned      pad;
    logic [PIX_W-1:0] px;
    logic             row_end;
    out_t             r;
    s = (scale_r == 0) ? 1 : (scale_r > MAX_SCALE) ? MAX_SCALE : scale_r;
    w = (width_r == 0) ? 1 : (width_r > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : width_r;
    r = '0;
    if ((b.operation == OP_REPLAY) != replaying) begin
      r.kind = KIND_ERR;
      r.last = 1'b1;
      beats_due.push_back(r);
      return;
    end
    if (b.operation == OP_PIXEL) begin
      line_buf[column] = b.pixel;
      px = b.pixel;
    end else begin
      px = line_buf[column];
    end
    row_end = (column + 1 >= w);
    r.kind = KIND_COPY;
    r.pixel_out = px;
    for (int i = 0; i < s; i++) begin
      r.last = !row_end && (i == s - 1);
      beats_due.push_back(r);
    end
    column++;
    if (row_end) begin
      pad = (4 - (w * s * 3) % 4) % 4;
      r = '0;
      r.kind = KIND_PAD;
      r.pad_bytes = pad[1:0];
      r.row_done = 1'b1;
      r.last = 1'b1;
      beats_due.push_back(r);
      column = 0;
      row_pass++;
      if (row_pass >= s) begin
        row_pass = 0;
        replaying = 1'b0;
      end else begin
        replaying = 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scale_r = SCALE_W'(1);
      width_r = WIDTH_W'(1);
      column = 0;
      row_pass = 0;
      replaying = 1'b0;
      beats_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SCALE) scale_r = cfg_wdata[SCALE_W-1:0];
        else if (cfg_index == REG_ROW_WIDTH) width_r = cfg_wdata[WIDTH_W-1:0];
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (beats_due.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual %0h",
                   $time, out_data);
          fail_count++;
        end else begin
          head = beats_due.pop_front();
          check_field("kind", head.kind, out_data.kind);
          check_field("pixel_out", head.pixel_out, out_data.pixel_out);
          check_field("pad_bytes", head.pad_bytes, out_data.pad_bytes);
          check_field("row_done", head.row_done, out_data.row_done);
          check_field("last", head.last, out_data.last);
        end
      end
      if (in_valid && !in_stall) upscale_beat(in_data);
    end
  end

endmodule

FILE: sim/pixel_replication_upscaler_core_test.sv
`timescale 1ns / 100ps

module pixel_replication_upscaler_core_test;
  import pru_pkg::*;

  localparam int ITEM_TARGET   = 360;
  localparam int CALM_AFTER    = 300;     // no idling on either side past this beat count
  localparam int HOLD_AFTER    = 60;      // long receiver hold-off starts after this many beats
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 24;      // a little over one beat's worst case
  localparam int TIMEOUT_NS    = 6000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_count;
  int pending;
  int results_seen;

  // where the source row stands, kept only to shape the stimulus
  int unsigned eff_s;
  int unsigned eff_w;
  int unsigned tcol;
  int unsigned tpass;
  logic        treplay;

  int   beats_sent;
  int   noise_sent;
  int   settings_used;
  logic next_op;

  // shared with the receiver process; both change only through NBAs
  logic calm     = 1'b0;
  logic hold_req = 1'b0;

  pixel_replication_upscaler_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pixel_replication_upscaler_core_check check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Drop valid, let the checker see the last accepted beat,
  // then wait for every expected result to drain and let the core settle.
  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers every time; two back-to-back writes keep cfg_we high
  // across the pair so it only gets one NBA per step.
  task automatic set_geometry(input logic [CFG_W-1:0] s_val, input logic [CFG_W-1:0] w_val);
    go_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCALE;
    cfg_wdata <= s_val;
    @(posedge clk);
    cfg_index <= REG_ROW_WIDTH;
    cfg_wdata <= w_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_s = (s_val[SCALE_W-1:0] == 0) ? 1 :
            (s_val[SCALE_W-1:0] > MAX_SCALE) ? MAX_SCALE : s_val[SCALE_W-1:0];
    eff_w = (w_val[WIDTH_W-1:0] == 0) ? 1 :
            (w_val[WIDTH_W-1:0] > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : w_val[WIDTH_W-1:0];
    settings_used++;
  endtask

  // Offer one input beat, hold it until taken, then advance the row position if the beat was in sequence.
  task automatic offer(input logic op, input logic [PIX_W-1:0] px);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, px};
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (!calm && beats_sent >= CALM_AFTER) calm <= 1'b1;
    if (op == (treplay ? OP_REPLAY : OP_PIXEL)) begin
      tcol++;
      if (tcol >= eff_w) begin
        tcol = 0;
        tpass++;
        if (tpass >= eff_s) begin
          tpass = 0;
          treplay = 1'b0;
        end else begin
          treplay = 1'b1;
        end
      end
    end else begin
      noise_sent++;   // out of sequence: position unchanged
    end
  endtask

  // Random geometry. Mid-row changes stay small; during a replay the width
  // may not grow so no never-written line buffer entry gets read.
  task automatic pick_geometry(input bit mid);
    logic [CFG_W-1:0] s_val;
    logic [CFG_W-1:0] w_val;
    int unsigned      roll;
    roll = $urandom_range(0, 9);
    if (mid) s_val = CFG_W'($urandom_range(1, 4));
    else if (roll < 6) s_val = CFG_W'($urandom_range(1, 3));
    else if (roll < 8) s_val = CFG_W'($urandom_range(4, 8));
    else if (roll == 8) s_val = CFG_W'(MAX_SCALE);
    else s_val = CFG_W'($urandom_range(0, 1) ? 0 : $urandom_range(17, 31));
    // bits above the scale field are junk the core must drop
    if ($urandom_range(0, 3) == 0)
      s_val[CFG_W-1:SCALE_W] = (CFG_W - SCALE_W)'($urandom_range(0, 63));
    if (mid && treplay) w_val = CFG_W'($urandom_range(1, eff_w));
    else if (s_val[SCALE_W-1:0] >= 8) w_val = CFG_W'($urandom_range(1, 3));
    else w_val = CFG_W'($urandom_range(0, 12));
    set_geometry(s_val, w_val);
  endtask

  // Receiver: random stall bursts, open stretches, and one long hold-off that
  // lets the core back up and push stall onto the sender.
  initial begin : receiver
    bit held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SCALE;
    cfg_wdata <= '0;
    eff_s = 1;
    eff_w = 1;
    tcol = 0;
    tpass = 0;
    treplay = 1'b0;
    beats_sent = 0;
    noise_sent = 0;
    settings_used = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry 1 x 1: copy plus a one-byte pad, then a stray replay
    offer(OP_PIXEL, 24'h000000);
    offer(OP_REPLAY, 24'hFFFFFF);

    // 2 x 2 with a stray pixel at the start of the replay pass
    set_geometry(2, 2);
    offer(OP_PIXEL, 24'hFFFFFF);
    offer(OP_PIXEL, 24'h000000);
    offer(OP_PIXEL, 24'h123456);
    offer(OP_REPLAY, 24'h000000);
    offer(OP_REPLAY, 24'hFFFFFF);

    // zero in both registers behaves as one
    set_geometry(0, 0);
    offer(OP_PIXEL, 24'hA5A5A5);

    // scale above the limit clamps to 16; mid-replay shrink to 1 x 1 ends
    // the row and the whole replay on the next beat
    set_geometry(31, 3);
    offer(OP_PIXEL, 24'h5A5A5A);
    offer(OP_PIXEL, 24'hFFFFFF);
    offer(OP_PIXEL, 24'h000001);
    offer(OP_REPLAY, 24'h800000);
    set_geometry(1, 1);
    offer(OP_REPLAY, 24'h7FFFFF);

    // oversized width clamps to the buffer size; shrinking mid-row ends the
    // row early (pad of three bytes at 1 x 3)
    set_geometry(3, 2047);
    offer(OP_PIXEL, PIX_W'($urandom_range(0, 24'hFFFFFF)));
    offer(OP_PIXEL, PIX_W'($urandom_range(0, 24'hFFFFFF)));
    set_geometry(3, 1);
    offer(OP_PIXEL, PIX_W'($urandom_range(0, 24'hFFFFFF)));
    offer(OP_REPLAY, PIX_W'($urandom_range(0, 24'hFFFFFF)));
    offer(OP_REPLAY, PIX_W'($urandom_range(0, 24'hFFFFFF)));

    // random part: mostly well-formed rows and replays, some stray beats
    while (beats_sent < ITEM_TARGET || treplay || tcol != 0) begin
      if (!treplay && tcol == 0) begin
        if ($urandom_range(0, 2) == 0) pick_geometry(1'b0);
        if (!hold_req && beats_sent > HOLD_AFTER) hold_req <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        pick_geometry(1'b1);
      end
      next_op = treplay ? OP_REPLAY : OP_PIXEL;
      if ($urandom_range(0, 11) == 0)
        repeat ($urandom_range(1, 3))
          offer(~next_op, PIX_W'($urandom_range(0, 24'hFFFFFF)));
      offer(next_op, PIX_W'($urandom_range(0, 24'hFFFFFF)));
    end

    go_quiet();
    $display("Covered %0d input beats (%0d out of sequence) over %0d register settings,",
             beats_sent, noise_sent, settings_used);
    $display("  %0d result beats checked, one %0d-cycle receiver hold-off included.",
             results_seen, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("** pixel_replication_upscaler_core: PASSED **");
    end else begin
      $display("** pixel_replication_upscaler_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d result beats still expected", pending);
    $display("** pixel_replication_upscaler_core: FAILED **");
    $finish;
  end

endmodule
